/* rtl/bsrs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary split radix sorter package
// Sequencer states and fixed constants shared by the sorter RTL.
// ----------------------------------------------------------------------------
package bsrs_pkg;

    // Width of the largest-value configuration register.
    localparam int unsigned CFG_WIDTH = 32;

    // Reset value of the largest-value register: every bit considered.
    localparam logic [CFG_WIDTH-1:0] LARGEST_RESET = {CFG_WIDTH{1'b1}};

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_COUNT,
        ST_SPLIT,
        ST_EMIT_RD,
        ST_EMIT_WAIT,
        ST_EMIT_HOLD
    } state_t;

endpackage

/* rtl/binary_split_radix_sorter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Operation: a set of n keys loads at one key per cycle, then sorts in P passes,
// each a counting scan and a split scan, then emits keys one at a time, each held until taken.
// P is the top set bit of largest_value plus one, at least 1, at most KEY_WIDTH.
// Sets are handled one at a time: no key is taken while a set sorts or emits.
// Reset (rst_n low, asynchronous): empty set, largest_value all ones, no output.
// ----------------------------------------------------------------------------
// Binary split radix sorter
// Loads up to CAPACITY unsigned keys, sorts them by a stable LSB-first binary
// radix sort over two ping-pong key buffers, and emits them in ascending order.
// ----------------------------------------------------------------------------
module binary_split_radix_sorter
    import bsrs_pkg::*;
#(
    parameter int unsigned CAPACITY  = 64,
    parameter int unsigned KEY_WIDTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_write_en,
    input  logic [CFG_WIDTH-1:0] cfg_write_data,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [KEY_WIDTH-1:0] key_in,
    input  logic                 final_key,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [KEY_WIDTH-1:0] key_out,
    output logic                 final_out
);

    // Address width of the key buffers, width of counts that can hold CAPACITY
    // itself, and width of the pass index (which selects one key bit).
    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned PW = (KEY_WIDTH > 1) ? $clog2(KEY_WIDTH) : 1;

    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);
    localparam logic [PW-1:0] LAST_PASS = PW'(KEY_WIDTH - 1);

    // Ping-pong key buffers. Loads always go to buffer A; each split pass reads
    // the current source buffer and writes the other one.
    logic [KEY_WIDTH-1:0] mem_a [CAPACITY];
    logic [KEY_WIDTH-1:0] mem_b [CAPACITY];

    state_t               state_reg, state_next;
    logic [CFG_WIDTH-1:0] largest_value_reg;
    logic [CW-1:0]        cnt_reg, cnt_next;          // keys stored in this set
    logic [CW-1:0]        idx_reg, idx_next;          // read index into the source
    logic                 rd_vld_reg, rd_vld_next;    // read data belongs to a key
    logic [CW-1:0]        zcnt_reg, zcnt_next;        // keys with a zero bit this pass
    logic [CW-1:0]        zpos_reg, zpos_next;        // next slot for a zero-bit key
    logic [CW-1:0]        opos_reg, opos_next;        // next slot for a one-bit key
    logic [PW-1:0]        pass_reg, pass_next;        // bit examined by this pass
    logic [CFG_WIDTH-1:0] lv_shift_reg, lv_shift_next;// largest_value above this pass
    logic                 sel_reg, sel_next;          // 1 when buffer B is the source
    logic                 out_valid_reg, out_valid_next;
    logic [KEY_WIDTH-1:0] key_out_reg, key_out_next;
    logic                 final_out_reg, final_out_next;
    logic [KEY_WIDTH-1:0] rd_a_reg, rd_b_reg;

    logic                 in_accept;
    logic                 out_take;
    logic                 issue;
    logic                 scan_done;
    logic                 more_passes;
    logic [KEY_WIDTH-1:0] rd_key;
    logic                 cur_bit;
    logic [AW-1:0]        raddr;
    logic                 wr_a, wr_b;
    logic [AW-1:0]        waddr;
    logic [KEY_WIDTH-1:0] wdata;

    assign in_stall  = (state_reg != ST_LOAD);
    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;

    assign out_valid = out_valid_reg;
    assign key_out   = key_out_reg;
    assign final_out = final_out_reg;

    // One buffer read per cycle at the running index. An index equal to the
    // set size only occurs after the last key and its data is never used.
    assign raddr   = idx_reg[AW-1:0];
    assign rd_key  = sel_reg ? rd_b_reg : rd_a_reg;
    assign cur_bit = rd_key[pass_reg];

    assign issue       = (idx_reg != cnt_reg);
    assign scan_done   = (idx_reg == cnt_reg) && rd_vld_reg;
    assign more_passes = (lv_shift_reg != '0) && (pass_reg != LAST_PASS);

    // A split writes the key either behind the zero-bit keys or behind the
    // one-bit keys, which start right after all zero-bit keys.
    always_comb
    begin
        wr_a  = 1'b0;
        wr_b  = 1'b0;
        waddr = cur_bit ? opos_reg[AW-1:0] : zpos_reg[AW-1:0];
        wdata = rd_key;
        if (state_reg == ST_LOAD)
        begin
            wr_a  = in_accept && (cnt_reg < CAP_COUNT);
            waddr = cnt_reg[AW-1:0];
            wdata = key_in;
        end
        else if (state_reg == ST_SPLIT && rd_vld_reg)
        begin
            wr_a = sel_reg;
            wr_b = !sel_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_a_reg <= mem_a[raddr];
        if (wr_a)
        begin
            mem_a[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_b_reg <= mem_b[raddr];
        if (wr_b)
        begin
            mem_b[waddr] <= wdata;
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_accept && final_key)
                begin
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                if (scan_done)
                begin
                    state_next = ST_SPLIT;
                end
            end
            ST_SPLIT:
            begin
                if (scan_done)
                begin
                    state_next = more_passes ? ST_COUNT : ST_EMIT_RD;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT:
            begin
                state_next = ST_EMIT_HOLD;
            end
            ST_EMIT_HOLD:
            begin
                if (out_take)
                begin
                    state_next = final_out_reg ? ST_LOAD : ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Datapath and output next values.
    always_comb
    begin
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        rd_vld_next    = rd_vld_reg;
        zcnt_next      = zcnt_reg;
        zpos_next      = zpos_reg;
        opos_next      = opos_reg;
        pass_next      = pass_reg;
        lv_shift_next  = lv_shift_reg;
        sel_next       = sel_reg;
        out_valid_next = out_valid_reg;
        key_out_next   = key_out_reg;
        final_out_next = final_out_reg;

        case (state_reg)
            ST_LOAD:
            begin
                if (in_accept)
                begin
                    // Keys beyond capacity are dropped; the final flag still counts.
                    if (cnt_reg < CAP_COUNT)
                    begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                    if (final_key)
                    begin
                        idx_next      = '0;
                        rd_vld_next   = 1'b0;
                        zcnt_next     = '0;
                        pass_next     = '0;
                        sel_next      = 1'b0;
                        lv_shift_next = largest_value_reg >> 1;
                    end
                end
            end
            ST_COUNT:
            begin
                if (issue)
                begin
                    idx_next = idx_reg + CW'(1);
                end
                rd_vld_next = issue;
                if (rd_vld_reg && !cur_bit)
                begin
                    zcnt_next = zcnt_reg + CW'(1);
                end
                if (scan_done)
                begin
                    idx_next    = '0;
                    rd_vld_next = 1'b0;
                    zpos_next   = '0;
                    opos_next   = zcnt_next;
                end
            end
            ST_SPLIT:
            begin
                if (issue)
                begin
                    idx_next = idx_reg + CW'(1);
                end
                rd_vld_next = issue;
                if (rd_vld_reg)
                begin
                    if (cur_bit)
                    begin
                        opos_next = opos_reg + CW'(1);
                    end
                    else
                    begin
                        zpos_next = zpos_reg + CW'(1);
                    end
                end
                if (scan_done)
                begin
                    idx_next    = '0;
                    rd_vld_next = 1'b0;
                    zcnt_next   = '0;
                    sel_next    = !sel_reg;
                    if (more_passes)
                    begin
                        pass_next     = pass_reg + PW'(1);
                        lv_shift_next = lv_shift_reg >> 1;
                    end
                end
            end
            ST_EMIT_RD:
            begin
                // The read at the running index is under way this cycle.
            end
            ST_EMIT_WAIT:
            begin
                out_valid_next = 1'b1;
                key_out_next   = rd_key;
                final_out_next = ((idx_reg + CW'(1)) == cnt_reg);
            end
            ST_EMIT_HOLD:
            begin
                if (out_take)
                begin
                    out_valid_next = 1'b0;
                    if (final_out_reg)
                    begin
                        cnt_next = '0;
                        idx_next = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_LOAD;
            largest_value_reg <= LARGEST_RESET;
            cnt_reg           <= '0;
            idx_reg           <= '0;
            rd_vld_reg        <= 1'b0;
            zcnt_reg          <= '0;
            zpos_reg          <= '0;
            opos_reg          <= '0;
            pass_reg          <= '0;
            lv_shift_reg      <= '0;
            sel_reg           <= 1'b0;
            out_valid_reg     <= 1'b0;
            final_out_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_write_en)
            begin
                largest_value_reg <= cfg_write_data;
            end
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            rd_vld_reg    <= rd_vld_next;
            zcnt_reg      <= zcnt_next;
            zpos_reg      <= zpos_next;
            opos_reg      <= opos_next;
            pass_reg      <= pass_next;
            lv_shift_reg  <= lv_shift_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
            final_out_reg <= final_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_out_reg <= key_out_next;
    end

    // Zero-bit keys never spill into the region reserved for one-bit keys.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SPLIT) |-> (zpos_reg <= zcnt_reg) && (opos_reg <= cnt_reg))
        else $error("split write positions left their regions");

    // A set being sorted or emitted is never empty and never above capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> (cnt_reg != '0) && (cnt_reg <= CAP_COUNT))
        else $error("set size out of range while sorting");

    // After the last sorted key is taken, the block is ready for a new set.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && final_out_reg) |=> !in_stall && (cnt_reg == '0))
        else $error("block did not return to loading after the last key");

    // No result is offered except while the emit sequence holds it.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (state_reg == ST_EMIT_HOLD))
        else $error("result offered outside the emit sequence");

endmodule
